FILE: hw/rtl/ecgd_pkg.sv
// Shared types, operation codes, constants and tables for the ECEF to geodetic block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ecgd_pkg;

    // Datapath operations, issued one at a time by the controller
    localparam logic [4:0] U_E2   = 5'd0;
    localparam logic [4:0] U_EE   = 5'd1;
    localparam logic [4:0] U_BAX  = 5'd2;
    localparam logic [4:0] U_LON  = 5'd3;
    localparam logic [4:0] U_R    = 5'd4;
    localparam logic [4:0] U_ROV  = 5'd5;
    localparam logic [4:0] U_RO   = 5'd6;
    localparam logic [4:0] U_G    = 5'd7;
    localparam logic [4:0] U_PA   = 5'd8;
    localparam logic [4:0] U_PB   = 5'd9;
    localparam logic [4:0] U_NORM = 5'd10;
    localparam logic [4:0] U_LAT0 = 5'd11;
    localparam logic [4:0] U_SC   = 5'd12;
    localparam logic [4:0] U_S2   = 5'd13;
    localparam logic [4:0] U_W    = 5'd14;
    localparam logic [4:0] U_RW   = 5'd15;
    localparam logic [4:0] U_N    = 5'd16;
    localparam logic [4:0] U_T1   = 5'd17;
    localparam logic [4:0] U_T2   = 5'd18;
    localparam logic [4:0] U_LATV = 5'd19;
    localparam logic [4:0] U_HQ   = 5'd20;
    localparam logic [4:0] U_HN   = 5'd21;
    localparam logic [4:0] U_H    = 5'd22;

    // Unit that carries out an operation
    localparam logic [2:0] K_MUL  = 3'd0;
    localparam logic [2:0] K_DIV  = 3'd1;
    localparam logic [2:0] K_SQRT = 3'd2;
    localparam logic [2:0] K_COR  = 3'd3;
    localparam logic [2:0] K_NORM = 3'd4;
    localparam logic [2:0] K_ALU  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_FLAT   = 2'd1;
    localparam logic [1:0] REG_ITER   = 2'd2;

    localparam logic [32:0] RADIUS_RST = 33'd6378136600;
    localparam logic [30:0] FLAT_RST   = 31'd14400251;
    localparam logic [7:0]  ITER_RST   = 8'd100;

    localparam logic [63:0] KINV32 = 64'd2608131496;
    localparam logic signed [63:0] KINV30 = 64'sd652032874;
    localparam logic signed [63:0] QTURN  = 64'sd1073741824;
    localparam logic signed [33:0] ANG_Q    = 34'sd1073741824;
    localparam logic signed [33:0] ANG_HALF = 34'sd2147483648;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [4:0] uop;
        logic       emit;
    } ecgd_cmd_t;

    typedef struct packed {
        logic done;
        logic origin;
    } ecgd_stat_t;

    // CORDIC arctangent table, binary angle units
    function automatic logic [29:0] atab(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] uop_kind(input logic [4:0] u);
        logic [2:0] k;
        case (u)
            U_EE, U_N, U_HQ:                      k = K_DIV;
            U_RW:                                 k = K_SQRT;
            U_LON, U_ROV, U_LAT0, U_SC, U_LATV:   k = K_COR;
            U_NORM:                               k = K_NORM;
            U_H:                                  k = K_ALU;
            default:                              k = K_MUL;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ecgd_ctrl.sv
// Sequencer for the ECEF to geodetic block: handshakes, operation order, iteration count.
// Depends on ecgd_pkg; drives the datapath through ecgd_cmd_t.
`default_nettype none

module ecgd_ctrl
    import ecgd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] iteration_count,
    input  wire ecgd_stat_t stat,
    output ecgd_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [4:0] uop_reg, uop_next;
    logic [7:0] k_reg, k_next;
    logic       m_valid_reg, m_valid_next;
    logic [4:0] follow;

    // Pick the operation after the current one
    always_comb begin
        case (uop_reg)
            U_N:     follow = (k_reg < iteration_count) ? U_T1 : U_HQ;
            U_LATV:  follow = U_SC;
            default: follow = 5'(uop_reg + 5'd1);
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        uop_next     = uop_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.start    = 1'b0;
        cmd.emit     = 1'b0;
        cmd.uop      = uop_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    k_next   = 8'd0;
                    uop_next = U_E2;
                    state_next = stat.origin ? ST_OUT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (stat.done) begin
                    if (uop_reg == U_H) begin
                        state_next = ST_OUT;
                    end else begin
                        uop_next   = follow;
                        state_next = ST_ISSUE;
                        if (uop_reg == U_LATV) begin
                            k_next = 8'(k_reg + 8'd1);
                        end
                    end
                end
            end
            ST_OUT: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            uop_reg     <= U_E2;
            k_reg       <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            uop_reg     <= uop_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ecgd_dpath.sv
// Datapath of the ECEF to geodetic block: shared multiplier, divider, square root,
// CORDIC and the working registers. Depends on ecgd_pkg; commanded by ecgd_ctrl.
`default_nettype none

module ecgd_dpath
    import ecgd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ecgd_cmd_t   cmd,
    output ecgd_stat_t       stat,
    input  wire logic [36:0] s_position_x,
    input  wire logic [36:0] s_position_y,
    input  wire logic [36:0] s_position_z,
    input  wire logic [32:0] radius,
    input  wire logic [30:0] flat,
    output logic [31:0]      m_latitude,
    output logic [31:0]      m_longitude,
    output logic [36:0]      m_height,
    output logic             m_degenerate
);

    // Working registers
    logic [63:0] xq_reg, yq_reg, zq_reg;
    logic        origin_reg;
    logic [31:0] e2_reg;
    logic [63:0] ee_reg, bax_reg, r_reg, ro_reg, g_reg;
    logic [127:0] pa_reg, pb_reg;
    logic signed [33:0] lat_reg, lon_reg;
    logic [63:0] s_reg, c_reg, tmp_reg, t_reg, n_reg, hq_reg, hn_reg;
    logic [30:0] w_reg, rw_reg;
    logic        hsel_reg;
    logic [36:0] h_reg;

    // Shared units
    logic [63:0]  ma_reg, mb_reg, pp_reg;
    logic [1:0]   psh_reg;
    logic [127:0] acc_reg;
    logic [63:0]  dv_rem_reg, dv_lo_reg, dv_d_reg, dv_q_reg;
    logic [63:0]  sq_n_reg, sq_res_reg, sq_bit_reg;
    logic signed [63:0] cx_reg, cy_reg;
    logic signed [33:0] ca_reg;
    logic         cvec_reg, cspec_reg;

    // Control
    logic       busy_reg, done_reg;
    logic [6:0] cnt_reg;
    logic [4:0] uop_reg;

    // Output register
    logic [31:0] out_lat_reg, out_lon_reg;
    logic [36:0] out_h_reg;
    logic        out_deg_reg;

    logic [2:0]  kind, start_kind;
    logic        norm_more, run, fin;
    logic [63:0] abs_s, abs_c, az;

    logic [63:0] op_ma, op_mb, op_hi, op_lo, op_d, op_sq;
    logic signed [63:0] cor_x, cor_y;
    logic        cor_vec, hsel_c, dv_special;
    logic signed [63:0] ci_x, ci_y;
    logic signed [33:0] ci_a;
    logic        ci_spec;
    logic [6:0]  start_cnt;

    assign kind       = uop_kind(uop_reg);
    assign start_kind = uop_kind(cmd.uop);
    assign norm_more  = (|pa_reg[127:52]) || (|pb_reg[127:52]);
    assign run = busy_reg && ((kind == K_NORM) ? norm_more : (cnt_reg != 7'd0));
    assign fin = busy_reg && !run;
    assign abs_s = abs64(s_reg);
    assign abs_c = abs64(c_reg);
    assign az    = abs64(zq_reg);
    assign hsel_c = abs_c < abs_s;

    assign stat.done   = done_reg;
    assign stat.origin = (s_position_x == 37'd0) && (s_position_y == 37'd0) &&
                         (s_position_z == 37'd0);

    // Operand selection for the operation being started
    always_comb begin
        op_ma   = 64'd0;
        op_mb   = 64'd0;
        op_hi   = 64'd0;
        op_lo   = 64'd0;
        op_d    = 64'd0;
        op_sq   = 64'd0;
        cor_x   = 64'sd0;
        cor_y   = 64'sd0;
        cor_vec = 1'b1;
        case (cmd.uop)
            U_E2: begin
                op_ma = 64'(flat);
                op_mb = 64'h2_0000_0000 - 64'(flat);
            end
            U_EE: begin
                op_lo = {e2_reg, 32'd0};
                op_d  = 64'h1_0000_0000 - 64'(e2_reg);
            end
            U_BAX: begin
                op_ma = 64'(radius);
                op_mb = 64'h1_0000_0000 - 64'(flat);
            end
            U_LON: begin
                cor_x = xq_reg;
                cor_y = yq_reg;
            end
            U_R, U_RO: begin
                op_ma = cx_reg;
                op_mb = KINV32;
            end
            U_ROV: begin
                cor_x = r_reg;
                cor_y = zq_reg;
            end
            U_G: begin
                op_ma = ee_reg;
                op_mb = bax_reg;
            end
            U_PA: begin
                op_ma = r_reg;
                op_mb = ro_reg;
            end
            U_PB: begin
                op_ma = az;
                op_mb = g_reg;
            end
            U_LAT0: begin
                cor_x = pa_reg[63:0];
                cor_y = zq_reg[63] ? 64'(-pb_reg[63:0]) : pb_reg[63:0];
            end
            U_SC: cor_vec = 1'b0;
            U_S2: begin
                op_ma = abs_s;
                op_mb = abs_s;
            end
            U_W: begin
                op_ma = 64'(e2_reg);
                op_mb = tmp_reg;
            end
            U_RW: op_sq = 64'({w_reg, 30'd0});
            U_N: begin
                op_hi = 64'(radius[32:18]);
                op_lo = {radius[17:0], 46'd0};
                op_d  = 64'(rw_reg);
            end
            U_T1: begin
                op_ma = n_reg;
                op_mb = 64'(e2_reg);
            end
            U_T2: begin
                op_ma = tmp_reg;
                op_mb = abs_s;
            end
            U_LATV: begin
                cor_x = r_reg;
                cor_y = zq_reg + (s_reg[63] ? 64'(-t_reg) : t_reg);
            end
            U_HQ: begin
                if (hsel_c) begin
                    op_hi = az >> 34;
                    op_lo = az << 30;
                    op_d  = abs_s;
                end else begin
                    op_hi = r_reg >> 34;
                    op_lo = r_reg << 30;
                    op_d  = abs_c;
                end
            end
            U_HN: begin
                op_ma = n_reg;
                op_mb = hsel_reg ? (64'h1_0000_0000 - 64'(e2_reg)) : 64'h1_0000_0000;
            end
            default: op_ma = 64'd0;
        endcase
    end

    assign dv_special = (op_d == 64'd0) || (op_hi >= op_d);

    // CORDIC start: axis cases are exact; when vectoring, others fold into the right half plane
    always_comb begin
        ci_x    = 64'sd0;
        ci_y    = 64'sd0;
        ci_a    = 34'sd0;
        ci_spec = 1'b1;
        if (cor_vec) begin
            if (cor_x == 64'sd0) begin
                ci_x = abs64(cor_y);
                if (cor_y > 64'sd0) begin
                    ci_a = ANG_Q;
                end else if (cor_y < 64'sd0) begin
                    ci_a = -ANG_Q;
                end
            end else if (cor_y == 64'sd0) begin
                ci_x = abs64(cor_x);
                ci_a = cor_x[63] ? ANG_HALF : 34'sd0;
            end else begin
                ci_spec = 1'b0;
                if (cor_x[63]) begin
                    ci_x = -cor_x;
                    ci_y = -cor_y;
                    ci_a = ANG_HALF;
                end else begin
                    ci_x = cor_x;
                    ci_y = cor_y;
                end
            end
        end else begin
            if (lat_reg == ANG_Q) begin
                ci_y = QTURN;
            end else if (lat_reg == -ANG_Q) begin
                ci_y = -QTURN;
            end else if (lat_reg == 34'sd0) begin
                ci_x = QTURN;
            end else begin
                ci_spec = 1'b0;
                ci_x    = KINV30;
                ci_a    = lat_reg;
            end
        end
    end

    always_comb begin
        case (start_kind)
            K_MUL:  start_cnt = ((cmd.uop == U_R || cmd.uop == U_RO) && cspec_reg) ?
                                7'd0 : 7'd5;
            K_DIV:  start_cnt = dv_special ? 7'd0 : 7'd64;
            K_SQRT: start_cnt = 7'd32;
            K_COR:  start_cnt = ci_spec ? 7'd0 : 7'd32;
            default: start_cnt = 7'd0;
        endcase
    end

    // Unit step signals
    logic [2:0]  mul_idx;
    logic [31:0] mul_ah, mul_bh;
    logic [63:0] mul_pp;
    logic [64:0] dv_rem65, dv_sub;
    logic        dv_ge;
    logic [63:0] sq_sum;
    logic        sq_ge;
    logic [4:0]  cor_i;
    logic signed [63:0] cor_dx, cor_dy;
    logic        cor_plus;
    logic [33:0] cor_at;

    assign mul_idx = 3'(7'd5 - cnt_reg);
    assign mul_ah  = mul_idx[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign mul_bh  = mul_idx[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign mul_pp  = {32'd0, mul_ah} * {32'd0, mul_bh};

    assign dv_rem65 = {dv_rem_reg, dv_lo_reg[63]};
    assign dv_ge    = dv_rem65 >= {1'b0, dv_d_reg};
    assign dv_sub   = dv_rem65 - {1'b0, dv_d_reg};

    assign sq_sum = sq_res_reg + sq_bit_reg;
    assign sq_ge  = sq_n_reg >= sq_sum;

    assign cor_i    = 5'(7'd32 - cnt_reg);
    assign cor_dx   = cy_reg >>> cor_i;
    assign cor_dy   = cx_reg >>> cor_i;
    assign cor_plus = cvec_reg ? (cy_reg > 64'sd0) : ca_reg[33];
    assign cor_at   = {4'd0, atab(cor_i)};

    // Height: signed quotient less the radius term, rounded and saturated
    logic        hq_neg;
    logic [63:0] h_q, h_1, h_2;
    logic signed [63:0] h_3;
    logic [36:0] h_sat;
    logic signed [63:0] w_full;

    always_comb begin
        hq_neg = hsel_reg ? (zq_reg[63] ^ s_reg[63]) : c_reg[63];
        h_q = hq_neg ? 64'(-hq_reg) : hq_reg;
        h_1 = h_q - hn_reg;
        h_2 = h_1 + 64'd32768;
        h_3 = $signed(h_2) >>> 16;
        if (!h_3[63] && (|h_3[62:36])) begin
            h_sat = {1'b0, {36{1'b1}}};
        end else if (h_3[63] && !(&h_3[62:36])) begin
            h_sat = {1'b1, 36'd0};
        end else begin
            h_sat = h_3[36:0];
        end
        w_full = QTURN - $signed(acc_reg[95:32]);
    end

    // Control state of the shared units
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            uop_reg  <= U_E2;
        end else begin
            done_reg <= fin;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= start_cnt;
                uop_reg  <= cmd.uop;
            end else begin
                if (fin) begin
                    busy_reg <= 1'b0;
                end
                if (run && kind != K_NORM) begin
                    cnt_reg <= 7'(cnt_reg - 7'd1);
                end
            end
        end
    end

    // Operand loading, unit steps and write-back
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            xq_reg     <= {{11{s_position_x[36]}}, s_position_x, 16'd0};
            yq_reg     <= {{11{s_position_y[36]}}, s_position_y, 16'd0};
            zq_reg     <= {{11{s_position_z[36]}}, s_position_z, 16'd0};
            origin_reg <= stat.origin;
        end
        if (cmd.start) begin
            case (start_kind)
                K_MUL: begin
                    ma_reg  <= op_ma;
                    mb_reg  <= op_mb;
                    pp_reg  <= 64'd0;
                    psh_reg <= 2'd0;
                    acc_reg <= 128'd0;
                end
                K_DIV: begin
                    dv_rem_reg <= op_hi;
                    dv_lo_reg  <= op_lo;
                    dv_d_reg   <= op_d;
                    dv_q_reg   <= dv_special ? {64{1'b1}} : 64'd0;
                    if (cmd.uop == U_HQ) begin
                        hsel_reg <= hsel_c;
                    end
                end
                K_SQRT: begin
                    sq_n_reg   <= op_sq;
                    sq_res_reg <= 64'd0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                end
                K_COR: begin
                    cx_reg    <= ci_x;
                    cy_reg    <= ci_y;
                    ca_reg    <= ci_a;
                    cvec_reg  <= cor_vec;
                    cspec_reg <= ci_spec;
                end
                default: ;
            endcase
        end else if (run) begin
            case (kind)
                K_MUL: begin
                    acc_reg <= acc_reg + (128'(pp_reg) << {psh_reg, 5'd0});
                    pp_reg  <= mul_pp;
                    psh_reg <= 2'(mul_idx[1]) + 2'(mul_idx[0]);
                end
                K_DIV: begin
                    dv_rem_reg <= dv_ge ? dv_sub[63:0] : dv_rem65[63:0];
                    dv_lo_reg  <= dv_lo_reg << 1;
                    dv_q_reg   <= {dv_q_reg[62:0], dv_ge};
                end
                K_SQRT: begin
                    sq_n_reg   <= sq_ge ? (sq_n_reg - sq_sum) : sq_n_reg;
                    sq_res_reg <= sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                K_COR: begin
                    if (cor_plus) begin
                        cx_reg <= cx_reg + cor_dx;
                        cy_reg <= cy_reg - cor_dy;
                        ca_reg <= ca_reg + $signed(cor_at);
                    end else begin
                        cx_reg <= cx_reg - cor_dx;
                        cy_reg <= cy_reg + cor_dy;
                        ca_reg <= ca_reg - $signed(cor_at);
                    end
                end
                K_NORM: begin
                    pa_reg <= pa_reg >> 1;
                    pb_reg <= pb_reg >> 1;
                end
                default: ;
            endcase
        end
        if (fin) begin
            case (uop_reg)
                U_E2:   e2_reg  <= acc_reg[63:32];
                U_EE:   ee_reg  <= dv_q_reg;
                U_BAX:  bax_reg <= acc_reg[79:16];
                U_LON:  lon_reg <= ca_reg;
                U_R:    r_reg   <= cspec_reg ? cx_reg : acc_reg[95:32];
                U_RO:   ro_reg  <= cspec_reg ? cx_reg : acc_reg[95:32];
                U_G:    g_reg   <= ro_reg + acc_reg[95:32];
                U_PA:   pa_reg  <= acc_reg;
                U_PB:   pb_reg  <= acc_reg;
                U_LAT0: lat_reg <= ca_reg;
                U_SC: begin
                    s_reg <= cy_reg;
                    c_reg <= cx_reg;
                end
                U_S2:   tmp_reg <= acc_reg[93:30];
                U_W:    w_reg   <= (w_full < 64'sd1) ? 31'd1 : w_full[30:0];
                U_RW:   rw_reg  <= (sq_res_reg == 64'd0) ? 31'd1 : sq_res_reg[30:0];
                U_N:    n_reg   <= dv_q_reg;
                U_T1:   tmp_reg <= acc_reg[95:32];
                U_T2:   t_reg   <= acc_reg[93:30];
                U_LATV: lat_reg <= ca_reg;
                U_HQ:   hq_reg  <= dv_q_reg;
                U_HN:   hn_reg  <= acc_reg[95:32];
                U_H:    h_reg   <= h_sat;
                default: ;
            endcase
        end
        // Transfer the finished item into the output register
        if (cmd.emit) begin
            if (origin_reg) begin
                out_lat_reg <= 32'd0;
                out_lon_reg <= 32'd0;
                out_h_reg   <= 37'd0;
                out_deg_reg <= 1'b1;
            end else begin
                out_lat_reg <= lat_reg[31:0];
                out_lon_reg <= lon_reg[31:0];
                out_h_reg   <= h_reg;
                out_deg_reg <= 1'b0;
            end
        end
    end

    assign m_latitude   = out_lat_reg;
    assign m_longitude  = out_lon_reg;
    assign m_height     = out_h_reg;
    assign m_degenerate = out_deg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ecef_to_geodetic_converter_top.sv
// Top level of the ECEF to geodetic converter: configuration registers, sequencer, datapath.
// Depends on ecgd_pkg, ecgd_ctrl and ecgd_dpath.
//
// Usage: present an Earth-centered position (s_position_x/y/z, signed mm) on the input
// channel with s_valid; it transfers when s_valid and s_ready are both high. One result
// per position appears on the output channel (m_latitude, m_longitude as binary angles
// with 2^32 per turn, m_height in mm, m_degenerate for the origin) and transfers when
// m_valid and m_ready are both high.
// One shared multiplier (5 steps), a bit-serial divider (64 steps), a square-root unit
// (32 steps) and a CORDIC (32 steps) run one after another. The refinement loop
// (U_T1 to U_N) runs iteration_count times per item; the normalize step runs until both
// products fit in 52 bits, so its length depends on the input. The origin skips the
// computation and goes straight to the output. Items are worked one at a time; s_ready
// is high whenever no item is in work.
// A finished result sits in the output register while the next item is accepted; if
// the receiver stalls, the next result waits until the register is free.
// Reset (aresetn low, synchronous) loads the configuration registers with their defaults
// and empties the block. Write cfg_index/cfg_wr_data with cfg_wr_en only while idle.
`default_nettype none

module ecef_to_geodetic_converter_top
    import ecgd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [36:0] s_position_x,
    input  wire logic [36:0] s_position_y,
    input  wire logic [36:0] s_position_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_latitude,
    output logic [31:0]      m_longitude,
    output logic [36:0]      m_height,
    output logic             m_degenerate,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [32:0] cfg_wr_data
);

    logic [32:0] radius_reg;
    logic [30:0] flat_reg;
    logic [7:0]  iter_reg;
    ecgd_cmd_t   cmd;
    ecgd_stat_t  stat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            flat_reg   <= FLAT_RST;
            iter_reg   <= ITER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_wr_data;
                REG_FLAT:   flat_reg   <= cfg_wr_data[30:0];
                REG_ITER:   iter_reg   <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    ecgd_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .iteration_count (iter_reg),
        .stat            (stat),
        .cmd             (cmd)
    );

    ecgd_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_position_x (s_position_x),
        .s_position_y (s_position_y),
        .s_position_z (s_position_z),
        .radius       (radius_reg),
        .flat         (flat_reg),
        .m_latitude   (m_latitude),
        .m_longitude  (m_longitude),
        .m_height     (m_height),
        .m_degenerate (m_degenerate)
    );

endmodule

`default_nettype wire
